/* design/jsl_pkg.sv */
// Package for the joint slew limiter: codes, field widths, the per-joint
// record type and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jsl_pkg;

   localparam int unsigned KindWidth  = 2;
   localparam int unsigned IndexWidth = 8;
   localparam int unsigned DataWidth  = 32;
   localparam int unsigned CsrWidth   = 31;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned MaxUsed    = 8;

   localparam logic [KindWidth-1:0] KIND_SET_TARGET  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_TICK        = 2'd1;
   localparam logic [KindWidth-1:0] KIND_FORCE_ERROR = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_BAD_IDX = 2'd2;

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_WORKING = 2'd1;
   localparam logic [1:0] MODE_ERROR   = 2'd2;

   localparam logic [CsrIdxWidth-1:0] REG_JOINT_COUNT  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] REG_TICK_SECONDS = 2'd1;
   localparam logic [CsrIdxWidth-1:0] REG_TICK_RATE    = 2'd2;
   localparam logic [CsrIdxWidth-1:0] REG_MIN_SPEED    = 2'd3;

   typedef struct packed {
      logic signed [DataWidth-1:0] pos;
      logic signed [DataWidth-1:0] vel;
      logic signed [DataWidth-1:0] gpos;
      logic signed [DataWidth-1:0] gspd;
   } joint_rec_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_STEP,
      S_VEL,
      S_WRITE,
      S_OUT
   } seq_state_type;

endpackage
`default_nettype wire

/* design/joint_slew_limiter_unit.sv */
// Top level of the joint slew limiter: configuration registers, sequencer,
// shared step arithmetic at the head of the joint ring, and result register.
// Depends on jsl_pkg and jsl_cell.
//
// The joints sit in a ring of cells that rotates past one shared arithmetic
// head. A set_target or force_error transfer gives one result. A tick makes
// two full turns of the ring: a compute turn taking each joint in use
// through the multiply, step, velocity and write states and passing each
// other ring position straight on, then a report turn giving one result per
// joint in use. In error mode the compute turn is skipped. A new transfer is
// not taken while a stalled result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module joint_slew_limiter_unit #(
   parameter int unsigned JOINTS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_kind,
   input  wire logic [7:0]         req_joint_index,
   input  wire logic signed [31:0] req_target_position,
   input  wire logic signed [31:0] req_target_speed,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [2:0]              rsp_joint_number,
   output logic signed [31:0]      rsp_position,
   output logic signed [31:0]      rsp_velocity,
   output logic [1:0]              rsp_mode,
   output logic                    rsp_last,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [30:0]        csr_wdata
);
   import jsl_pkg::*;

   localparam int unsigned CW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam logic [CW-1:0] CntLast = CW'(JOINTS - 1);

   logic [3:0]  joint_count_ff;
   logic [15:0] tick_seconds_ff;
   logic [15:0] tick_rate_ff;
   logic [30:0] min_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         joint_count_ff  <= 4'd8;
         tick_seconds_ff <= 16'd655;
         tick_rate_ff    <= 16'd100;
         min_speed_ff    <= 31'd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_JOINT_COUNT:  joint_count_ff  <= csr_wdata[3:0];
            REG_TICK_SECONDS: tick_seconds_ff <= csr_wdata[15:0];
            REG_TICK_RATE:    tick_rate_ff    <= csr_wdata[15:0];
            REG_MIN_SPEED:    min_speed_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [7:0] n_used;
   always_comb begin
      n_used = 8'(joint_count_ff);
      if (n_used > 8'(JOINTS)) n_used = 8'(JOINTS);
      if (n_used > 8'(MaxUsed)) n_used = 8'(MaxUsed);
   end

   seq_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    mode_ff, mode_in;
   logic          moving_ff, moving_in;
   logic [47:0]   prod1_ff;
   logic signed [31:0] stp_ff;
   logic signed [48:0] prod2_ff;

   logic rsp_valid_ff;
   logic [1:0] rsp_status_ff, rsp_mode_ff;
   logic [2:0] rsp_joint_number_ff;
   logic signed [31:0] rsp_position_ff, rsp_velocity_ff;
   logic rsp_last_ff;

   joint_rec_type rec [JOINTS];
   joint_rec_type head_new;

   logic accept, out_free, cnt_in_use, cnt_at_end;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept     = req_valid && !req_stall;
   assign cnt_in_use = 8'(cnt_ff) < n_used;
   assign cnt_at_end = cnt_ff == CntLast;

   // Head arithmetic.
   logic [31:0] spd_abs, spd;
   logic [31:0] step_limit;
   logic signed [32:0] err, max_s33;
   logic signed [31:0] stp_c;
   logic signed [31:0] vel_sat;

   always_comb begin
      spd_abs = rec[0].gspd[31] ? 32'(-rec[0].gspd) : 32'(rec[0].gspd);
      spd = (spd_abs < {1'b0, min_speed_ff}) ? {1'b0, min_speed_ff} : spd_abs;
      step_limit = prod1_ff[47:16];
      max_s33 = {1'b0, step_limit};
      err = 33'(rec[0].gpos) - 33'(rec[0].pos);
      if (err > max_s33) begin
         stp_c = 32'(max_s33);
      end else if (err < -max_s33) begin
         stp_c = 32'(-max_s33);
      end else begin
         stp_c = 32'(err);
      end
      if (prod2_ff > 49'sd2147483647) begin
         vel_sat = 32'sh7FFFFFFF;
      end else if (prod2_ff < -49'sd2147483648) begin
         vel_sat = 32'sh80000000;
      end else begin
         vel_sat = 32'(prod2_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff <= 48'(spd) * 48'(tick_seconds_ff);
      stp_ff   <= stp_c;
      prod2_ff <= 49'(stp_ff) * $signed({33'd0, tick_rate_ff});
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_kind == KIND_TICK) begin
               state_in = (mode_ff == MODE_ERROR) ? S_OUT : S_MUL;
            end
         end
         S_MUL: begin
            if (cnt_in_use) begin
               state_in = S_STEP;
            end else if (cnt_at_end) begin
               state_in = S_OUT;
            end
         end
         S_STEP:  state_in = S_VEL;
         S_VEL:   state_in = S_WRITE;
         S_WRITE: state_in = cnt_at_end ? S_OUT : S_MUL;
         S_OUT: begin
            if ((!cnt_in_use || out_free) && cnt_at_end) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs.
   logic shift_en, vel_clr, load_out, goal_we_any;
   logic [1:0] out_status, out_mode;
   logic [2:0] out_jn;
   logic signed [31:0] out_pos, out_vel;
   logic out_last;

   always_comb begin
      shift_en    = 1'b0;
      vel_clr     = 1'b0;
      goal_we_any = 1'b0;
      load_out    = 1'b0;
      cnt_in      = cnt_ff;
      mode_in     = mode_ff;
      moving_in   = moving_ff;
      out_status  = STATUS_OK;
      out_mode    = mode_ff;
      out_jn      = '0;
      out_pos     = '0;
      out_vel     = '0;
      out_last    = 1'b1;
      head_new    = rec[0];
      unique case (state_ff)
         S_IDLE: begin
            cnt_in    = '0;
            moving_in = 1'b0;
            if (accept) begin
               priority if (req_kind == KIND_SET_TARGET) begin
                  load_out = 1'b1;
                  if (mode_ff == MODE_ERROR) begin
                     out_status = STATUS_REFUSED;
                  end else if (req_joint_index >= n_used) begin
                     out_status = STATUS_BAD_IDX;
                  end else begin
                     goal_we_any = 1'b1;
                  end
               end else if (req_kind == KIND_FORCE_ERROR) begin
                  load_out = 1'b1;
                  vel_clr  = 1'b1;
                  mode_in  = MODE_ERROR;
                  out_mode = MODE_ERROR;
               end else begin
               end
            end
         end
         S_MUL: begin
            if (!cnt_in_use) begin
               shift_en = 1'b1;
               cnt_in   = cnt_at_end ? '0 : cnt_ff + 1'b1;
               if (cnt_at_end) mode_in = moving_ff ? MODE_WORKING : MODE_IDLE;
            end
         end
         S_STEP: ;
         S_VEL: ;
         S_WRITE: begin
            shift_en     = 1'b1;
            head_new.pos = rec[0].pos + stp_ff;
            head_new.vel = vel_sat;
            moving_in    = moving_ff || (stp_ff != '0);
            cnt_in       = cnt_at_end ? '0 : cnt_ff + 1'b1;
            if (cnt_at_end) mode_in = moving_in ? MODE_WORKING : MODE_IDLE;
         end
         S_OUT: begin
            out_status = (mode_ff == MODE_ERROR) ? STATUS_REFUSED : STATUS_OK;
            out_jn     = 3'(cnt_ff);
            out_pos    = rec[0].pos;
            out_vel    = rec[0].vel;
            out_last   = 8'(cnt_ff) == n_used - 8'd1;
            if (!cnt_in_use || out_free) begin
               load_out = cnt_in_use;
               shift_en = 1'b1;
               cnt_in   = cnt_at_end ? '0 : cnt_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         mode_ff   <= MODE_IDLE;
         moving_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         mode_ff   <= mode_in;
         moving_ff <= moving_in;
      end
   end

   genvar k;
   generate
      for (k = 0; k < JOINTS; k++) begin : g_ring
         joint_rec_type nbr;
         if (k == JOINTS - 1) begin : g_tail
            assign nbr = head_new;
         end else begin : g_mid
            assign nbr = rec[k+1];
         end
         jsl_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .shift_in (nbr),
            .goal_we  (goal_we_any && (req_joint_index == 8'(k))),
            .goal_pos (req_target_position),
            .goal_spd (req_target_speed),
            .vel_clr  (vel_clr),
            .rec      (rec[k])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_status_ff       <= out_status;
         rsp_joint_number_ff <= out_jn;
         rsp_position_ff     <= out_pos;
         rsp_velocity_ff     <= out_vel;
         rsp_mode_ff         <= out_mode;
         rsp_last_ff         <= out_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_joint_number = rsp_joint_number_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_velocity     = rsp_velocity_ff;
   assign rsp_mode         = rsp_mode_ff;
   assign rsp_last         = rsp_last_ff;

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_TICK) |=> (state_ff != S_IDLE))
      else $error("tick transfer did not start a ring pass");

   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (cnt_ff == '0))
      else $error("ring counter not parked in idle");

   a_error_frozen: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_ERROR) |->
         (state_ff != S_STEP && state_ff != S_VEL && state_ff != S_WRITE))
      else $error("motion computed in error mode");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load_out)
      else $error("stalled result overwritten");

endmodule
`default_nettype wire

/* design/jsl_cell.sv */
// One cell of the joint ring: holds one joint record and takes its
// neighbor's record on a shift. Depends on jsl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jsl_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          shift_en,
   input  wire jsl_pkg::joint_rec_type        shift_in,
   input  wire logic                          goal_we,
   input  wire logic signed [31:0]            goal_pos,
   input  wire logic signed [31:0]            goal_spd,
   input  wire logic                          vel_clr,
   output jsl_pkg::joint_rec_type             rec
);
   import jsl_pkg::*;

   joint_rec_type rec_ff;
   joint_rec_type rec_in;

   always_comb begin
      rec_in = rec_ff;
      if (shift_en) begin
         rec_in = shift_in;
      end else if (goal_we) begin
         rec_in.gpos = goal_pos;
         rec_in.gspd = goal_spd;
      end else if (vel_clr) begin
         rec_in.vel = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign rec = rec_ff;

endmodule
`default_nettype wire
